>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs clk and rst to be visible in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while rst is high.
`define DOFN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DOFN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/dofn_pkg.sv
// Shared types and constants for the freedom numbering block.
// No dependencies.
package dofn_pkg;

  localparam int NODE_W = 12;   // node_index width
  localparam int NUM_W  = 14;   // freedom number width
  localparam int COMP_W = 2;    // component field width
  localparam int DIMS_W = 2;    // active_dims width

  localparam int MAX_NODES_DEF = 4096;
  localparam int MAX_DIMS_DEF  = 3;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;

  // front-to-back queue, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // config port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_ACTIVE_DIMS = 1'b0;  // word index

  typedef struct packed {
    logic                 assigned;
    logic [NUM_W-1:0]     num;
  } dofn_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dofn_qstat_t;

  typedef struct packed {
    logic clearing;
  } dofn_bstat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT
  } dofn_state_t;

endpackage

>>> hw/rtl/dofn_front.sv
// Front end: config register, input channel, request classification.
// Depends on dofn_pkg.
module dofn_front #(
  parameter int MAX_NODES = dofn_pkg::MAX_NODES_DEF,
  parameter int MAX_DIMS  = dofn_pkg::MAX_DIMS_DEF,
  localparam int NODE_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dofn_pkg::APB_AW-1:0]     paddr,
  input  logic [dofn_pkg::APB_DW-1:0]     pwdata,
  output logic [dofn_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  input  logic                            node_valid,
  output logic                            node_stall,
  input  logic [dofn_pkg::NODE_W-1:0]     node_index,
  input  dofn_pkg::dofn_qstat_t           qstat,
  input  dofn_pkg::dofn_bstat_t           bstat,
  output logic                            push,
  output logic [NODE_AW+dofn_pkg::DIMS_W-1:0] push_data
);
  import dofn_pkg::*;

  localparam int IDX_CMP_W = 17;

  logic [DIMS_W-1:0]    active_dims;
  logic [DIMS_W-1:0]    eff_dims;
  logic [IDX_CMP_W-1:0] idx_ext;
  logic                 in_range;
  logic                 accept;
  logic                 reg_hit;

  assign reg_hit = (paddr[APB_AW-1:2] == REG_ACTIVE_DIMS);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_dims <= DIMS_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      active_dims <= pwdata[DIMS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = APB_DW'(active_dims);
    end
  end

  // saturate to the built-in component count
  assign eff_dims = (active_dims > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : active_dims;

  assign idx_ext  = IDX_CMP_W'(node_index);
  assign in_range = (idx_ext < IDX_CMP_W'(MAX_NODES));

  assign node_stall = bstat.clearing || qstat.full;
  assign accept     = node_valid && !node_stall;

  // requests with no active component or an out-of-range node are dropped here
  assign push      = accept && in_range && (eff_dims != '0);
  assign push_data = {idx_ext[NODE_AW-1:0], eff_dims};

endmodule

>>> hw/rtl/dofn_queue.sv
// Short FIFO between front and back end.
// Depends on dofn_pkg.
module dofn_queue #(
  parameter int ENTRY_W = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [ENTRY_W-1:0]    push_data,
  input  logic                  pop,
  output logic [ENTRY_W-1:0]    pop_data,
  output dofn_pkg::dofn_qstat_t qstat
);
  import dofn_pkg::*;

  logic [ENTRY_W-1:0] slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign qstat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign pop_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/dofn_back.sv
// Back end: node table, number counter, per-component result sequencing.
// Depends on dofn_pkg.
module dofn_back #(
  parameter int MAX_NODES = dofn_pkg::MAX_NODES_DEF,
  parameter int MAX_DIMS  = dofn_pkg::MAX_DIMS_DEF,
  localparam int NODE_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dofn_pkg::dofn_qstat_t           qstat,
  input  logic [NODE_AW+dofn_pkg::DIMS_W-1:0] pop_data,
  output logic                            pop,
  output dofn_pkg::dofn_bstat_t           bstat,
  output logic                            dof_valid,
  input  logic                            dof_stall,
  output logic [dofn_pkg::NUM_W-1:0]      dof_number,
  output logic [dofn_pkg::COMP_W-1:0]     component,
  output logic                            newly_assigned,
  output logic                            last_of_node
);
  import dofn_pkg::*;

  localparam int COMP_AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  typedef dofn_entry_t [MAX_DIMS-1:0] row_t;

  row_t mem [MAX_NODES];

  dofn_state_t         state, state_next;
  row_t                rd_row, fwd_row, row_q;
  row_t                src_row, cur_row, upd_row, mem_wd;
  dofn_entry_t         cur_ent;
  logic [NODE_AW-1:0]  clear_addr, cur_addr, head_addr, mem_wa;
  logic [DIMS_W-1:0]   cur_dims, head_dims;
  logic [COMP_AW-1:0]  comp_q;
  logic [NUM_W-1:0]    next_free;
  logic                first_q, fwd_q;
  logic                emit, is_last, clear_last, mem_we;

  assign {head_addr, head_dims} = pop_data;

  // first component reads the table (or the row just written back to it)
  always_comb begin
    src_row = fwd_q ? fwd_row : rd_row;
    cur_row = first_q ? src_row : row_q;
    cur_ent = cur_row[comp_q];
    upd_row = cur_row;
    if (!cur_ent.assigned) begin
      upd_row[comp_q] = '{assigned: 1'b1, num: next_free};
    end
  end

  assign is_last    = (COMP_W'(comp_q) == (cur_dims - DIMS_W'(1)));
  assign clear_last = (clear_addr == NODE_AW'(MAX_NODES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!qstat.empty) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit && is_last && qstat.empty) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    emit           = 1'b0;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = cur_addr;
    mem_wd         = upd_row;
    bstat.clearing = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_wa         = clear_addr;
        mem_wd         = '0;
        bstat.clearing = 1'b1;
      end
      ST_IDLE: begin
        pop = !qstat.empty;
      end
      ST_EMIT: begin
        emit = !dof_valid || !dof_stall;
        if (emit && is_last) begin
          mem_we = 1'b1;
          pop    = !qstat.empty;
        end
      end
      default: begin
        bstat.clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (pop) begin
      rd_row <= mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_q    <= '0;
      first_q   <= 1'b0;
      fwd_q     <= 1'b0;
      next_free <= '0;
    end else begin
      if (pop) begin
        comp_q  <= '0;
        first_q <= 1'b1;
        // same node right after its write-back: table read is stale
        fwd_q   <= mem_we && (mem_wa == head_addr);
      end else if (emit) begin
        comp_q  <= comp_q + 1'b1;
        first_q <= 1'b0;
      end
      if (emit && !cur_ent.assigned) begin
        next_free <= next_free + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr <= head_addr;
      cur_dims <= head_dims;
      fwd_row  <= upd_row;
    end
    if (emit) begin
      row_q <= upd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dof_valid <= 1'b0;
    end else if (emit) begin
      dof_valid <= 1'b1;
    end else if (!dof_stall) begin
      dof_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dof_number     <= cur_ent.assigned ? cur_ent.num : next_free;
      component      <= COMP_W'(comp_q);
      newly_assigned <= !cur_ent.assigned;
      last_of_node   <= is_last;
    end
  end

endmodule

>>> hw/rtl/dof_first_seen_numbering_core.sv
// Top level of the first-seen freedom numbering block.
// Depends on dofn_pkg, dofn_front, dofn_queue, dofn_back.
//
// Usage:
//  - node channel (node_valid/node_stall/node_index): one node id per
//    transaction, in element-list order.
//  - dof channel (dof_valid/dof_stall/...): one transaction per active
//    component of the node, component 0 first, last_of_node on the final one.
//  - APB port: register 0 (byte address 0) is active_dims, reset 2. Values
//    above MAX_DIMS act as MAX_DIMS; 0 drops every request. Write only idle.
//  - Requests with zero dims or node_index >= MAX_NODES give no transaction.
// Flow: an accepted node is written to the queue, popped with its table row
//   read (from IDLE, or on the last result of the previous node), then
//   emitted one component result per cycle unless dof_stall holds the output;
//   one table row read-modify-write per node.
// Reset: the node table is swept clean, one row per cycle, over all MAX_NODES
//   rows (4096 by default) with node_stall high; APB writes are taken meanwhile.
// Stall: a stalled result holds in the output register; the back end waits
//   and the two-entry queue lets the front take further nodes until full.
module dof_first_seen_numbering_core #(
  parameter int MAX_NODES = dofn_pkg::MAX_NODES_DEF,
  parameter int MAX_DIMS  = dofn_pkg::MAX_DIMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dofn_pkg::APB_AW-1:0]  paddr,
  input  logic [dofn_pkg::APB_DW-1:0]  pwdata,
  output logic [dofn_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  // node requests
  input  logic                         node_valid,
  output logic                         node_stall,
  input  logic [dofn_pkg::NODE_W-1:0]  node_index,
  // freedom results
  output logic                         dof_valid,
  input  logic                         dof_stall,
  output logic [dofn_pkg::NUM_W-1:0]   dof_number,
  output logic [dofn_pkg::COMP_W-1:0]  component,
  output logic                         newly_assigned,
  output logic                         last_of_node
);
  import dofn_pkg::*;

  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ENTRY_W = NODE_AW + DIMS_W;

  dofn_qstat_t        qstat;
  dofn_bstat_t        bstat;
  logic               push, pop;
  logic [ENTRY_W-1:0] push_data, pop_data;

  // classify and enqueue
  dofn_front #(
    .MAX_NODES (MAX_NODES),
    .MAX_DIMS  (MAX_DIMS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_valid (node_valid),
    .node_stall (node_stall),
    .node_index (node_index),
    .qstat      (qstat),
    .bstat      (bstat),
    .push       (push),
    .push_data  (push_data)
  );

  dofn_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // table lookup, numbering, result sequencing
  dofn_back #(
    .MAX_NODES (MAX_NODES),
    .MAX_DIMS  (MAX_DIMS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .qstat          (qstat),
    .pop_data       (pop_data),
    .pop            (pop),
    .bstat          (bstat),
    .dof_valid      (dof_valid),
    .dof_stall      (dof_stall),
    .dof_number     (dof_number),
    .component      (component),
    .newly_assigned (newly_assigned),
    .last_of_node   (last_of_node)
  );

endmodule

>>> hw/rtl/dofn_checker.sv
// Port-level checks for the freedom numbering block, bound to the top level.
// Depends on dofn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dofn_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         dof_valid,
  input logic                         dof_stall,
  input logic [dofn_pkg::NUM_W-1:0]   dof_number,
  input logic [dofn_pkg::COMP_W-1:0]  component,
  input logic                         newly_assigned,
  input logic                         last_of_node
);
  import dofn_pkg::*;

  // next number expected on a fresh allocation
  logic [NUM_W-1:0] exp_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_new <= '0;
    end else if (dof_valid && !dof_stall && newly_assigned) begin
      exp_new <= exp_new + 1'b1;
    end
  end

  `DOFN_ASSERT(a_hold, (dof_valid && dof_stall) |=> (dof_valid && $stable(dof_number)), "stalled result changed")

  `DOFN_ASSERT(a_comp_seq, (dof_valid && !dof_stall && !last_of_node) |=> (dof_valid && (component == $past(component) + 2'd1)), "component sequence broken")

  `DOFN_ASSERT(a_new_num, (dof_valid && newly_assigned) |-> (dof_number == exp_new), "new number not consecutive")

  `DOFN_ASSERT_ALWAYS(a_rst_empty, rst |=> !dof_valid, "result valid after reset")

endmodule

bind dof_first_seen_numbering_core dofn_checker u_dofn_checker (
  .clk            (clk),
  .rst            (rst),
  .dof_valid      (dof_valid),
  .dof_stall      (dof_stall),
  .dof_number     (dof_number),
  .component      (component),
  .newly_assigned (newly_assigned),
  .last_of_node   (last_of_node)
);
